>>> rtl/extent_run_list_decoder_macros.svh
// assertion macros for the extent run-list decoder
// no dependencies; taken in by the files that carry assertions
`ifndef EXTENT_RUN_LIST_DECODER_MACROS_SVH
`define EXTENT_RUN_LIST_DECODER_MACROS_SVH

// same-cycle implication
`define ERLD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ERLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/erld_pkg.sv
// shared types and constants for the extent run-list decoder
// no dependencies
package erld_pkg;

    localparam int unsigned CLUSTER_SIZE_W = 22;
    localparam logic [CLUSTER_SIZE_W-1:0] CLUSTER_SIZE_RST = 22'd4096;

    typedef enum logic [1:0] {
        KIND_MAPPED = 2'd0,
        KIND_SPARSE = 2'd1,
        KIND_END    = 2'd2,
        KIND_TRUNC  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] block_count;
        logic [63:0] cluster_number;
        logic [4:0]  run_bytes;
    } t_run;

endpackage

>>> rtl/erld_parser.sv
// byte parser: header / count / offset state machine and the first result register
// depends on erld_pkg
module erld_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_load,
    input  logic [7:0]    i_data_byte,
    input  logic          i_list_start,
    input  logic          i_buffer_end,
    output logic          o_res_valid,
    output erld_pkg::t_run o_res
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_COUNT  = 2'd1,
        PH_OFFSET = 2'd2
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_count_len, n_count_len;
    logic [3:0]  r_offset_len, n_offset_len;
    logic [3:0]  r_idx, n_idx;
    logic [63:0] r_count_acc, n_count_acc;
    logic [63:0] r_offset_acc, n_offset_acc;
    logic [63:0] r_running, n_running;
    logic [4:0]  r_consumed, n_consumed;
    logic        r_res_valid;
    erld_pkg::t_run r_res;

    logic           emit;
    erld_pkg::t_run res;
    logic [3:0]     idx_inc;
    logic [4:0]     cons_inc;
    logic           is_header;
    logic [63:0]    oacc_ext;
    logic [63:0]    clus;

    function automatic logic [63:0] place_byte(input logic [63:0] acc, input logic [7:0] b,
                                               input logic [3:0] idx);
        logic [63:0] r;
        r = acc;
        if (!idx[3]) begin
            r[{idx[2:0], 3'b000} +: 8] = b;
        end
        return r;
    endfunction

    always_comb begin
        n_phase      = r_phase;
        n_count_len  = r_count_len;
        n_offset_len = r_offset_len;
        n_idx        = r_idx;
        n_count_acc  = r_count_acc;
        n_offset_acc = r_offset_acc;
        n_running    = i_list_start ? 64'd0 : r_running;
        n_consumed   = r_consumed;
        emit         = 1'b0;
        res          = '0;
        idx_inc      = r_idx + 4'd1;
        cons_inc     = r_consumed + 5'd1;
        oacc_ext     = '0;
        clus         = '0;
        is_header    = i_list_start || !((r_phase == PH_COUNT) || (r_phase == PH_OFFSET));

        if (is_header) begin
            n_count_len  = i_data_byte[3:0];
            n_offset_len = i_data_byte[7:4];
            n_consumed   = 5'd1;
            n_idx        = 4'd0;
            n_count_acc  = '0;
            n_offset_acc = '0;
            res.run_bytes = 5'd1;
            if (i_data_byte[3:0] == 4'd0) begin
                emit     = 1'b1;
                res.kind = erld_pkg::KIND_END;
                n_phase  = PH_HEADER;
            end else if (i_buffer_end) begin
                emit     = 1'b1;
                res.kind = erld_pkg::KIND_TRUNC;
                n_phase  = PH_HEADER;
            end else begin
                n_phase = PH_COUNT;
            end
        end else if (r_phase == PH_COUNT) begin
            n_consumed    = cons_inc;
            n_count_acc   = place_byte(r_count_acc, i_data_byte, r_idx);
            n_idx         = idx_inc;
            res.run_bytes = cons_inc;
            if (idx_inc >= r_count_len) begin
                if (r_offset_len == 4'd0) begin
                    emit            = 1'b1;
                    res.kind        = erld_pkg::KIND_SPARSE;
                    res.block_count = n_count_acc;
                    n_phase         = PH_HEADER;
                end else begin
                    n_phase = PH_OFFSET;
                    n_idx   = 4'd0;
                end
            end
            if (!emit && i_buffer_end) begin
                emit     = 1'b1;
                res.kind = erld_pkg::KIND_TRUNC;
                n_phase  = PH_HEADER;
            end
        end else begin
            n_consumed    = cons_inc;
            n_offset_acc  = place_byte(r_offset_acc, i_data_byte, r_idx);
            n_idx         = idx_inc;
            res.run_bytes = cons_inc;
            if (idx_inc >= r_offset_len) begin
                oacc_ext = n_offset_acc;
                if (!r_offset_len[3] && (r_running != 64'd0) && i_data_byte[7]) begin
                    oacc_ext = n_offset_acc
                             | (64'hFFFF_FFFF_FFFF_FFFF << {r_offset_len[2:0], 3'b000});
                end
                clus               = r_running + oacc_ext;
                n_offset_acc       = oacc_ext;
                n_running          = clus;
                emit               = 1'b1;
                res.kind           = erld_pkg::KIND_MAPPED;
                res.block_count    = r_count_acc;
                res.cluster_number = clus;
                n_phase            = PH_HEADER;
            end else if (i_buffer_end) begin
                emit     = 1'b1;
                res.kind = erld_pkg::KIND_TRUNC;
                n_phase  = PH_HEADER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_count_len  <= '0;
            r_offset_len <= '0;
            r_idx        <= '0;
            r_count_acc  <= '0;
            r_offset_acc <= '0;
            r_running    <= '0;
            r_consumed   <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            if (i_accept) begin
                r_phase      <= n_phase;
                r_count_len  <= n_count_len;
                r_offset_len <= n_offset_len;
                r_idx        <= n_idx;
                r_count_acc  <= n_count_acc;
                r_offset_acc <= n_offset_acc;
                r_running    <= n_running;
                r_consumed   <= n_consumed;
            end
            if (i_load) begin
                r_res_valid <= i_accept && emit;
            end
        end
        if (i_load) begin
            r_res <= res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

>>> rtl/erld_scale.sv
// 64 x 22 bit product wrapping at 64 bits, in two registered steps
// depends on erld_pkg
module erld_scale (
    input  logic                                i_clk,
    input  logic                                i_en_pp,
    input  logic                                i_en_sum,
    input  logic [63:0]                         i_a,
    input  logic [erld_pkg::CLUSTER_SIZE_W-1:0] i_b,
    output logic [63:0]                         o_p
);

    localparam int unsigned LO_W = 32 + erld_pkg::CLUSTER_SIZE_W;

    logic [LO_W-1:0] r_lo;
    logic [31:0]     r_hi;
    logic [63:0]     r_p;
    logic [LO_W-1:0] hi_full;

    assign hi_full = i_a[63:32] * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en_pp) begin
            r_lo <= i_a[31:0] * i_b;
            r_hi <= hi_full[31:0];
        end
        if (i_en_sum) begin
            r_p <= {{(64-LO_W){1'b0}}, r_lo} + {r_hi, 32'd0};
        end
    end

    assign o_p = r_p;

endmodule

>>> rtl/extent_run_list_decoder.sv
// extent run-list decoder top level: handshake, configuration and pipeline
// depends on erld_pkg, erld_parser, erld_scale and the macros header
//
// usage
// - input channel: one run-list byte per transaction with list_start and
//   buffer_end; a transaction completes when i_in_valid is high and
//   o_in_stall is low
// - output channel: one run descriptor per transaction on o_out_valid,
//   taken when i_out_stall is low; bytes that finish no run give none
// - cluster size is written with i_cfg_wr_en / i_cfg_wr_data while idle
// - pipeline: a result passes the parser register, partial product register
//   and sum register after the byte that ends the run
// - throughput: one byte per cycle while o_in_stall is low; the cluster-size scaling
//   runs as two 32 x 22 partial products per product followed by a 64 bit add
// - reset: parser returns to expecting a header, running cluster cleared,
//   cluster size back to 4096, pipeline emptied
// - stall: the three stages hold their contents; o_in_stall rises only once
//   every stage holds a result and the receiver stalls
`include "extent_run_list_decoder_macros.svh"

module extent_run_list_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [erld_pkg::CLUSTER_SIZE_W-1:0] i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_list_start,
    input  logic                                i_buffer_end,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_run_kind,
    output logic [63:0]                         o_block_count,
    output logic [63:0]                         o_cluster_number,
    output logic [63:0]                         o_byte_offset,
    output logic [63:0]                         o_size_bytes,
    output logic [4:0]                          o_run_bytes
);

    logic [erld_pkg::CLUSTER_SIZE_W-1:0] r_cluster_size;
    logic           r_s2_valid, r_s3_valid;
    erld_pkg::t_run r_s2_run, r_s3_run;

    logic           s1_valid;
    erld_pkg::t_run s1_run;
    logic           s1_rdy, s2_rdy, s3_rdy;
    logic           in_accept;

    assign s3_rdy    = !r_s3_valid || !i_out_stall;
    assign s2_rdy    = !r_s2_valid || s3_rdy;
    assign s1_rdy    = !s1_valid || s2_rdy;
    assign in_accept = i_in_valid && s1_rdy;

    erld_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_load       (s1_rdy),
        .i_data_byte  (i_data_byte),
        .i_list_start (i_list_start),
        .i_buffer_end (i_buffer_end),
        .o_res_valid  (s1_valid),
        .o_res        (s1_run)
    );

    erld_scale u_scale_offset (
        .i_clk    (i_clk),
        .i_en_pp  (s2_rdy),
        .i_en_sum (s3_rdy),
        .i_a      (s1_run.cluster_number),
        .i_b      (r_cluster_size),
        .o_p      (o_byte_offset)
    );

    erld_scale u_scale_size (
        .i_clk    (i_clk),
        .i_en_pp  (s2_rdy),
        .i_en_sum (s3_rdy),
        .i_a      (s1_run.block_count),
        .i_b      (r_cluster_size),
        .o_p      (o_size_bytes)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_size <= erld_pkg::CLUSTER_SIZE_RST;
            r_s2_valid     <= 1'b0;
            r_s3_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cluster_size <= i_cfg_wr_data;
            end
            if (s2_rdy) begin
                r_s2_valid <= s1_valid;
            end
            if (s3_rdy) begin
                r_s3_valid <= r_s2_valid;
            end
        end
        if (s2_rdy) begin
            r_s2_run <= s1_run;
        end
        if (s3_rdy) begin
            r_s3_run <= r_s2_run;
        end
    end

    assign o_in_stall       = !s1_rdy;
    assign o_out_valid      = r_s3_valid;
    assign o_run_kind       = r_s3_run.kind;
    assign o_block_count    = r_s3_run.block_count;
    assign o_cluster_number = r_s3_run.cluster_number;
    assign o_run_bytes      = r_s3_run.run_bytes;

    `ERLD_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall,
        s1_valid && r_s2_valid && r_s3_valid && i_out_stall,
        "input stalled with room in the pipeline")
    `ERLD_ASSERT_NOW(a_end_is_one_byte, i_clk, i_rst_n,
        o_out_valid && (o_run_kind == erld_pkg::KIND_END),
        (o_run_bytes == 5'd1) && (o_block_count == 64'd0) && (o_size_bytes == 64'd0),
        "end of list carries data")
    `ERLD_ASSERT_NOW(a_unmapped_no_cluster, i_clk, i_rst_n,
        o_out_valid && (o_run_kind != erld_pkg::KIND_MAPPED),
        (o_cluster_number == 64'd0) && (o_byte_offset == 64'd0),
        "unmapped run has a cluster")
    `ERLD_ASSERT_NOW(a_run_bytes_nonzero, i_clk, i_rst_n, o_out_valid,
        o_run_bytes != 5'd0, "run with zero bytes")
    `ERLD_ASSERT_NEXT(a_stage_advances, i_clk, i_rst_n, r_s2_valid && s3_rdy,
        r_s3_valid, "result lost between scale stages")

endmodule

>>> dv/testbench.sv
// testbench for extent_run_list_decoder: feeds run-list bytes, predicts each run descriptor
// and checks every output transaction against the oldest prediction
// depends on erld_pkg and the extent_run_list_decoder rtl
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 1050;

    typedef logic [erld_pkg::CLUSTER_SIZE_W-1:0] t_csize;

    typedef enum logic [1:0] {
        PARSE_HEADER = 2'd0,
        PARSE_COUNT  = 2'd1,
        PARSE_OFFSET = 2'd2
    } t_parse_phase;

    typedef struct {
        erld_pkg::t_kind kind;
        logic [63:0]     block_count;
        logic [63:0]     cluster_number;
        logic [63:0]     byte_offset;
        logic [63:0]     size_bytes;
        logic [4:0]      run_bytes;
    } t_run_desc;

    logic                                i_clk;
    logic                                i_rst_n          = 1'b0;
    logic                                i_cfg_wr_en      = 1'b0;
    logic [erld_pkg::CLUSTER_SIZE_W-1:0] i_cfg_wr_data    = '0;
    logic                                i_in_valid       = 1'b0;
    logic                                o_in_stall;
    logic [7:0]                          i_data_byte      = 8'h00;
    logic                                i_list_start     = 1'b0;
    logic                                i_buffer_end     = 1'b0;
    logic                                o_out_valid;
    logic                                i_out_stall      = 1'b0;
    logic [1:0]                          o_run_kind;
    logic [63:0]                         o_block_count;
    logic [63:0]                         o_cluster_number;
    logic [63:0]                         o_byte_offset;
    logic [63:0]                         o_size_bytes;
    logic [4:0]                          o_run_bytes;

    // decoder state mirrored by the predictor
    t_parse_phase                        ph          = PARSE_HEADER;
    logic [3:0]                          cnt_len     = '0;
    logic [3:0]                          off_len     = '0;
    logic [3:0]                          fidx        = '0;
    logic [63:0]                         cnt_acc     = '0;
    logic [63:0]                         off_acc     = '0;
    logic [63:0]                         cur_cluster = '0;
    logic [4:0]                          used_bytes  = '0;
    logic [erld_pkg::CLUSTER_SIZE_W-1:0] cluster_bytes = erld_pkg::CLUSTER_SIZE_RST;

    t_run_desc pending_runs[$];
    int        err_count    = 0;
    int        bytes_sent   = 0;
    int        idle_cycles  = 0;
    int        stall_left   = 0;
    int        in_gap_mode  = 0;
    int        out_stall_mode = 0;

    extent_run_list_decoder u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_list_start     (i_list_start),
        .i_buffer_end     (i_buffer_end),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_run_kind       (o_run_kind),
        .o_block_count    (o_block_count),
        .o_cluster_number (o_cluster_number),
        .o_byte_offset    (o_byte_offset),
        .o_size_bytes     (o_size_bytes),
        .o_run_bytes      (o_run_bytes)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // every finished run returns the parser to expecting a header
    function automatic t_run_desc make_run(erld_pkg::t_kind k, logic [63:0] cnt,
                                           logic [63:0] clus, logic [4:0] nb);
        t_run_desc r;
        r.kind           = k;
        r.block_count    = cnt;
        r.cluster_number = clus;
        r.byte_offset    = clus * {42'd0, cluster_bytes};
        r.size_bytes     = cnt * {42'd0, cluster_bytes};
        r.run_bytes      = nb;
        ph = PARSE_HEADER;
        return r;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic st, input logic be,
                                       output t_run_desc r);
        if (st) begin
            cur_cluster = '0;
            ph = PARSE_HEADER;
        end
        if (ph != PARSE_COUNT && ph != PARSE_OFFSET) begin
            cnt_len    = b[3:0];
            off_len    = b[7:4];
            used_bytes = 5'd1;
            fidx       = '0;
            cnt_acc    = '0;
            off_acc    = '0;
            if (cnt_len == 4'd0) begin
                r = make_run(erld_pkg::KIND_END, 64'd0, 64'd0, 5'd1);
                return 1'b1;
            end
            ph = PARSE_COUNT;
            if (be) begin
                r = make_run(erld_pkg::KIND_TRUNC, 64'd0, 64'd0, used_bytes);
                return 1'b1;
            end
            return 1'b0;
        end
        used_bytes = used_bytes + 5'd1;
        if (ph == PARSE_COUNT) begin
            if (fidx < 4'd8)
                cnt_acc |= {56'd0, b} << (8 * fidx);
            fidx = fidx + 4'd1;
            if (fidx >= cnt_len) begin
                if (off_len == 4'd0) begin
                    r = make_run(erld_pkg::KIND_SPARSE, cnt_acc, 64'd0, used_bytes);
                    return 1'b1;
                end
                ph   = PARSE_OFFSET;
                fidx = '0;
            end
            if (be) begin
                r = make_run(erld_pkg::KIND_TRUNC, 64'd0, 64'd0, used_bytes);
                return 1'b1;
            end
            return 1'b0;
        end
        if (fidx < 4'd8)
            off_acc |= {56'd0, b} << (8 * fidx);
        fidx = fidx + 4'd1;
        if (fidx >= off_len) begin
            // negative deltas only once a cluster has been established
            if (off_len < 4'd8 && cur_cluster != 64'd0 && b[7])
                off_acc |= ~64'd0 << (8 * off_len);
            cur_cluster = cur_cluster + off_acc;
            r = make_run(erld_pkg::KIND_MAPPED, cnt_acc, cur_cluster, used_bytes);
            return 1'b1;
        end
        if (be) begin
            r = make_run(erld_pkg::KIND_TRUNC, 64'd0, 64'd0, used_bytes);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int pick_gap(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        return (r < 40) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom_range(8, 30);
    endfunction

    function automatic int pick_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic st, input logic be);
        int        gap;
        t_run_desc r;
        gap = pick_gap(in_gap_mode);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_list_start <= st;
        i_buffer_end <= be;
        do @(posedge i_clk); while (o_in_stall);
        if (decode_byte(b, st, be, r))
            pending_runs.push_back(r);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_cluster_size(input logic [erld_pkg::CLUSTER_SIZE_W-1:0] v);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cluster_bytes = v;
    endtask

    // one list: a few runs with random content, now and then cut short or restarted
    task automatic send_random_list();
        int         nruns;
        int         clen;
        int         olen;
        int         nb;
        int         cut;
        logic [7:0] v;
        logic       st;
        logic       be;
        bit         fresh;
        fresh = 1'b1;
        nruns = $urandom_range(1, 6);
        for (int k = 0; k < nruns; k++) begin
            clen = pick_len();
            olen = ($urandom_range(0, 3) == 0) ? 0 : pick_len();
            nb   = 1 + clen + olen;
            cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nb - 1) : -1;
            for (int j = 0; j < nb; j++) begin
                v  = (j == 0) ? {olen[3:0], clen[3:0]} : rand_byte();
                st = (j == 0 && fresh) || ($urandom_range(0, 99) == 0);
                be = (j == cut);
                send_byte(v, st, be);
                fresh = 1'b0;
                if (be)
                    break;
            end
        end
        if ($urandom_range(0, 4) != 0) begin
            v = 8'($urandom_range(0, 15) << 4);
            send_byte(v, 1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_run_kinds();
        in_gap_mode    = 0;
        out_stall_mode = 0;
        send_byte(8'h11, 1'b1, 1'b0);
        send_byte(8'h05, 1'b0, 1'b0);
        send_byte(8'h10, 1'b0, 1'b0);
        // negative delta back to cluster zero
        send_byte(8'h11, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'hf0, 1'b0, 1'b0);
        // top bit set but no sign extension from cluster zero
        send_byte(8'h21, 1'b0, 1'b0);
        send_byte(8'h02, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_long_fields();
        in_gap_mode = 1;
        send_byte(8'h09, 1'b1, 1'b0);
        repeat (9) send_byte(8'hff, 1'b0, 1'b0);
    endtask

    task automatic test_truncation();
        out_stall_mode = 1;
        send_byte(8'h11, 1'b0, 1'b1);
        send_byte(8'h22, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        send_byte(8'hf0, 1'b0, 1'b1);
    endtask

    task automatic test_cluster_sizes();
        logic [erld_pkg::CLUSTER_SIZE_W-1:0] sizes[4];
        sizes = '{22'd1, 22'h200000, 22'h3fffff, 22'd0};
        in_gap_mode    = 1;
        out_stall_mode = 1;
        foreach (sizes[i]) begin
            set_cluster_size(sizes[i]);
            repeat (3) send_random_list();
        end
        set_cluster_size(erld_pkg::CLUSTER_SIZE_RST);
    endtask

    task automatic test_random_lists();
        int                                  next_cfg;
        logic [erld_pkg::CLUSTER_SIZE_W-1:0] v;
        next_cfg = bytes_sent;
        while (bytes_sent < RANDOM_BYTES) begin
            if (bytes_sent >= next_cfg) begin
                case ($urandom_range(0, 5))
                    0: v = 22'd1;
                    1: v = 22'h3fffff;
                    2: v = t_csize'($urandom_range(1, 64));
                    3: v = 22'd1 << $urandom_range(9, 21);
                    default: v = t_csize'($urandom);
                endcase
                set_cluster_size(v);
                in_gap_mode    = $urandom_range(0, 2);
                out_stall_mode = $urandom_range(0, 2);
                next_cfg += 150;
            end
            send_random_list();
        end
    endtask

    always @(posedge i_clk) begin : out_side
        t_run_desc want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_runs.size() == 0) begin
                err_count++;
                $display("%0t: run descriptor with none expected, kind %0d count %h", $time,
                         o_run_kind, o_block_count);
            end else begin
                want = pending_runs.pop_front();
                check_field("run_kind", 64'(want.kind), 64'(o_run_kind));
                check_field("block_count", want.block_count, o_block_count);
                check_field("cluster_number", want.cluster_number, o_cluster_number);
                check_field("byte_offset", want.byte_offset, o_byte_offset);
                check_field("size_bytes", want.size_bytes, o_size_bytes);
                check_field("run_bytes", 64'(want.run_bytes), 64'(o_run_bytes));
            end
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (out_stall_mode != 0 &&
                     $urandom_range(0, 99) < ((out_stall_mode == 2) ? 30 : 10)) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_run_kinds();
        test_long_fields();
        test_truncation();
        test_cluster_sizes();
        test_random_lists();
        wait_idle();
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
